// ===== rtl/core/lcdtb_pkg.sv =====
package lcdtb_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned POS_W   = 13;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned PROD_W  = 2 * CH_W;
	localparam int unsigned NCH     = 3;

	// channel slots inside the per-pixel arrays
	localparam int unsigned CH_B = 0;
	localparam int unsigned CH_G = 1;
	localparam int unsigned CH_R = 2;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_TEXT_RED      = 3'd0,
		REG_TEXT_GREEN    = 3'd1,
		REG_TEXT_BLUE     = 3'd2,
		REG_SUBPIXEL_BGR  = 3'd3,
		REG_CANVAS_WIDTH  = 3'd4,
		REG_CANVAS_HEIGHT = 3'd5
	} cfg_reg_t;

	// floor(p / 255) for p up to 255*255: add the high byte and one, take bits 15:8
	function automatic chan_t div255(input prod_t p);
		logic [PROD_W:0] t;
		t = {1'b0, p} + {{(CH_W+1){1'b0}}, p[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
		return t[PROD_W-1:CH_W];
	endfunction

endpackage

// ===== rtl/core/lcdtb_pix_if.sv =====
interface lcdtb_pix_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [lcdtb_pkg::CH_W-1:0]               coverage_first;
	logic [lcdtb_pkg::CH_W-1:0]               coverage_middle;
	logic [lcdtb_pkg::CH_W-1:0]               coverage_last;
	logic [lcdtb_pkg::CH_W-1:0]               canvas_blue;
	logic [lcdtb_pkg::CH_W-1:0]               canvas_green;
	logic [lcdtb_pkg::CH_W-1:0]               canvas_red;
	logic [lcdtb_pkg::CH_W-1:0]               canvas_alpha;
	logic [lcdtb_pkg::CH_W-1:0]               strength;
	logic signed [lcdtb_pkg::POS_W-1:0]       pos_x;
	logic signed [lcdtb_pkg::POS_W-1:0]       pos_y;

	modport source(
		output valid, coverage_first, coverage_middle, coverage_last,
		output canvas_blue, canvas_green, canvas_red, canvas_alpha,
		output strength, pos_x, pos_y,
		input  ready
	);
	modport sink(
		input  valid, coverage_first, coverage_middle, coverage_last,
		input  canvas_blue, canvas_green, canvas_red, canvas_alpha,
		input  strength, pos_x, pos_y,
		output ready
	);
endinterface

interface lcdtb_pix_out_if;
	logic                           valid;
	logic                           ready;
	logic [lcdtb_pkg::COORD_W-1:0]  out_x;
	logic [lcdtb_pkg::COORD_W-1:0]  out_y;
	logic [lcdtb_pkg::CH_W-1:0]     new_blue;
	logic [lcdtb_pkg::CH_W-1:0]     new_green;
	logic [lcdtb_pkg::CH_W-1:0]     new_red;
	logic [lcdtb_pkg::CH_W-1:0]     new_alpha;

	modport source(
		output valid, out_x, out_y, new_blue, new_green, new_red, new_alpha,
		input  ready
	);
	modport sink(
		input  valid, out_x, out_y, new_blue, new_green, new_red, new_alpha,
		output ready
	);
endinterface

// ===== rtl/core/lcd_subpixel_text_blend_top.sv =====
// Channel   | Dir | Handshake     | Carries
// ----------+-----+---------------+------------------------------------------------
// pix_in    | in  | valid/ready   | coverage triple, canvas BGRA, strength, x, y
// pix_out   | out | valid/ready   | out_x, out_y, blended BGR, new alpha
// APB       | in  | psel/penable  | text colour, sub-pixel order, canvas size
//
// Five register stages; a kept pixel passes through s1 to s5 in order, and one pixel
// can enter every cycle while pix_in.ready is high.
// Each stage loads when it is empty or its successor moves, so bubbles collapse and
// pix_in.ready drops only when all five stages hold pixels and pix_out is stalled.
// Clipped pixels are dropped at the entry and never occupy a stage.
// arst_n clears all valid bits and the configuration registers; data registers keep.
module lcd_subpixel_text_blend_top (
	input  logic                              clk,
	input  logic                              arst_n,
	lcdtb_pix_in_if.sink                      pix_in,
	lcdtb_pix_out_if.source                   pix_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lcdtb_pkg::APB_AW-1:0]      paddr,
	input  logic [lcdtb_pkg::APB_DW-1:0]      pwdata,
	output logic [lcdtb_pkg::APB_DW-1:0]      prdata,
	output logic                              pready
);
	import lcdtb_pkg::*;

	// ---------------------------------------------------------------- config
	chan_t  text_red_q, text_green_q, text_blue_q;
	logic   subpixel_bgr_q;
	coord_t canvas_width_q, canvas_height_q;

	cfg_reg_t cfg_sel;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_red_q      <= '0;
			text_green_q    <= '0;
			text_blue_q     <= '0;
			subpixel_bgr_q  <= 1'b0;
			canvas_width_q  <= '0;
			canvas_height_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_TEXT_RED:      text_red_q      <= pwdata[CH_W-1:0];
				REG_TEXT_GREEN:    text_green_q    <= pwdata[CH_W-1:0];
				REG_TEXT_BLUE:     text_blue_q     <= pwdata[CH_W-1:0];
				REG_SUBPIXEL_BGR:  subpixel_bgr_q  <= pwdata[0];
				REG_CANVAS_WIDTH:  canvas_width_q  <= pwdata[COORD_W-1:0];
				REG_CANVAS_HEIGHT: canvas_height_q <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_sel)
			REG_TEXT_RED:      prdata[CH_W-1:0]    = text_red_q;
			REG_TEXT_GREEN:    prdata[CH_W-1:0]    = text_green_q;
			REG_TEXT_BLUE:     prdata[CH_W-1:0]    = text_blue_q;
			REG_SUBPIXEL_BGR:  prdata[0]           = subpixel_bgr_q;
			REG_CANVAS_WIDTH:  prdata[COORD_W-1:0] = canvas_width_q;
			REG_CANVAS_HEIGHT: prdata[COORD_W-1:0] = canvas_height_q;
			default:           prdata              = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// A stage advances when it is empty or its successor takes its pixel.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || pix_out.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1;

	// clip against the canvas; negative positions have the sign bit set
	logic on_canvas;
	assign on_canvas = !pix_in.pos_x[POS_W-1] && (pix_in.pos_x[COORD_W-1:0] < canvas_width_q) &&
	                   !pix_in.pos_y[POS_W-1] && (pix_in.pos_y[COORD_W-1:0] < canvas_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_in.valid && on_canvas;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Order coverage into B/G/R and capture the pixel.
	chan_t  cov_s1 [NCH];
	chan_t  dest_s1 [NCH];
	chan_t  alpha_s1, strength_s1;
	coord_t x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			cov_s1[CH_G]  <= pix_in.coverage_middle;
			cov_s1[CH_R]  <= subpixel_bgr_q ? pix_in.coverage_last  : pix_in.coverage_first;
			cov_s1[CH_B]  <= subpixel_bgr_q ? pix_in.coverage_first : pix_in.coverage_last;
			dest_s1[CH_B] <= pix_in.canvas_blue;
			dest_s1[CH_G] <= pix_in.canvas_green;
			dest_s1[CH_R] <= pix_in.canvas_red;
			alpha_s1      <= pix_in.canvas_alpha;
			strength_s1   <= pix_in.strength;
			x_s1          <= pix_in.pos_x[COORD_W-1:0];
			y_s1          <= pix_in.pos_y[COORD_W-1:0];
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Scale colour and coverage by strength. At full strength, c*255/255 is c
	// exactly, so the solid case needs no bypass.
	chan_t  col_c [NCH];
	prod_t  colp_s2 [NCH];
	prod_t  covp_s2 [NCH];
	chan_t  dest_s2 [NCH];
	chan_t  alpha_s2;
	coord_t x_s2, y_s2;

	assign col_c[CH_B] = text_blue_q;
	assign col_c[CH_G] = text_green_q;
	assign col_c[CH_R] = text_red_q;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int c = 0; c < NCH; c++) begin
				colp_s2[c] <= col_c[c]  * strength_s1;
				covp_s2[c] <= cov_s1[c] * strength_s1;
				dest_s2[c] <= dest_s1[c];
			end
			alpha_s2 <= alpha_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Divide the scaling products by 255.
	chan_t  col_s3 [NCH];
	chan_t  cov_s3 [NCH];
	chan_t  dest_s3 [NCH];
	chan_t  alpha_s3;
	coord_t x_s3, y_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int c = 0; c < NCH; c++) begin
				col_s3[c]  <= div255(colp_s2[c]);
				cov_s3[c]  <= div255(covp_s2[c]);
				dest_s3[c] <= dest_s2[c];
			end
			alpha_s3 <= alpha_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// Form |colour - dest| * coverage and keep the sign apart, so the divide
	// below truncates toward zero.
	logic [CH_W:0] diff_c [NCH];
	chan_t         mag_c [NCH];
	prod_t  prod_s4 [NCH];
	logic   neg_s4 [NCH];
	chan_t  dest_s4 [NCH];
	chan_t  alpha_s4;
	logic   keep_alpha_s4;
	coord_t x_s4, y_s4;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			diff_c[c] = {1'b0, col_s3[c]} - {1'b0, dest_s3[c]};
			mag_c[c]  = diff_c[c][CH_W] ? CH_W'(-diff_c[c]) : diff_c[c][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int c = 0; c < NCH; c++) begin
				prod_s4[c] <= mag_c[c] * cov_s3[c];
				neg_s4[c]  <= diff_c[c][CH_W];
				dest_s4[c] <= dest_s3[c];
			end
			alpha_s4      <= alpha_s3;
			keep_alpha_s4 <= (cov_s3[CH_B] == '0) && (cov_s3[CH_G] == '0) &&
			                 (cov_s3[CH_R] == '0);
			x_s4          <= x_s3;
			y_s4          <= y_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// Divide, reapply the sign and add to dest; this register is the output.
	chan_t  q_c [NCH];
	chan_t  new_s5 [NCH];
	chan_t  alpha_s5;
	coord_t x_s5, y_s5;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			q_c[c] = div255(prod_s4[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int c = 0; c < NCH; c++) begin
				new_s5[c] <= neg_s4[c] ? (dest_s4[c] - q_c[c]) : (dest_s4[c] + q_c[c]);
			end
			alpha_s5 <= keep_alpha_s4 ? alpha_s4 : '0;
			x_s5     <= x_s4;
			y_s5     <= y_s4;
		end
	end

	assign pix_out.valid     = v_s5;
	assign pix_out.out_x     = x_s5;
	assign pix_out.out_y     = y_s5;
	assign pix_out.new_blue  = new_s5[CH_B];
	assign pix_out.new_green = new_s5[CH_G];
	assign pix_out.new_red   = new_s5[CH_R];
	assign pix_out.new_alpha = alpha_s5;

endmodule

// ===== rtl/core/lcdtb_chk.sv =====
module lcdtb_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [lcdtb_pkg::COORD_W-1:0]     out_x,
	input logic [lcdtb_pkg::COORD_W-1:0]     out_y,
	input logic [lcdtb_pkg::CH_W-1:0]        new_blue,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [lcdtb_pkg::APB_AW-1:0]      paddr,
	input logic [lcdtb_pkg::APB_DW-1:0]      pwdata,
	input logic [lcdtb_pkg::APB_DW-1:0]      prdata
);
	import lcdtb_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(new_blue))
		else $error("result payload changed while stalled");

	// input backpressure only when the output side is blocked
	a_in_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// a write to the red colour register reads back on the next cycle
	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == '0) ##1 (psel && !pwrite && paddr == '0)
		|-> prdata == {{(APB_DW-CH_W){1'b0}}, $past(pwdata[CH_W-1:0])})
		else $error("colour register readback mismatch");

endmodule

bind lcd_subpixel_text_blend_top lcdtb_chk u_lcdtb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.out_x    (pix_out.out_x),
	.out_y    (pix_out.out_y),
	.new_blue (pix_out.new_blue),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
